// ----- hw/rtl/dcg_pkg.sv -----
// ----------------------------------------------------------------------------
// dcg_pkg
// shared types, widths, codes and saturation helpers of the disc step unit
// ----------------------------------------------------------------------------
package dcg_pkg;

   localparam int POS_W  = 12;
   localparam int VEL_W  = 16;
   localparam int IDX_W  = 3;
   localparam int CNT_W  = 4;
   localparam int DIFF_W = 13;
   localparam int D2_W   = 26;
   localparam int R2_W   = 18;
   localparam int ROOT_W = 18;
   localparam int SQ_W   = 36;
   localparam int GAP_W  = 19;
   localparam int DV_W   = 17;
   localparam int DOT_W  = 31;
   localparam int PROD_W = 45;
   localparam int DIVD_W = 44;
   localparam int DVS_W  = 18;
   localparam int DCNT_W = 6;
   localparam int WIDE_W = 46;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 11;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT_WALL    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BOTTOM_WALL   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DISC_RADIUS   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GRAVITY_STEP  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_COUNT  = 3'd4;

   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_FRAME = 1'b1;

   typedef struct packed {
      logic        [0:0]       req_type;
      logic        [IDX_W-1:0] disc_index;
      logic signed [POS_W-1:0] load_x;
      logic signed [POS_W-1:0] load_y;
      logic signed [VEL_W-1:0] load_vx;
      logic signed [VEL_W-1:0] load_vy;
   } req_item_type;

   typedef struct packed {
      logic        [IDX_W-1:0] out_index;
      logic signed [POS_W-1:0] out_x;
      logic signed [POS_W-1:0] out_y;
      logic signed [VEL_W-1:0] out_vx;
      logic signed [VEL_W-1:0] out_vy;
      logic        [0:0]       last_disc;
   } rsp_item_type;

   typedef struct packed {
      logic signed [POS_W-1:0] x;
      logic signed [POS_W-1:0] y;
      logic signed [VEL_W-1:0] vx;
      logic signed [VEL_W-1:0] vy;
   } disc_rec_type;

   typedef struct packed {
      logic [10:0] right_wall;
      logic [10:0] bottom_wall;
      logic [7:0]  disc_radius;
      logic [7:0]  gravity_step;
      logic [3:0]  active_count;
   } cfg_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD_A, OP_LOAD_B, OP_MOVE, OP_DIFF, OP_SQX, OP_SQY, OP_ZERO,
      OP_SQRT, OP_GAP, OP_PROD, OP_DIV, OP_TAKE, OP_PUSH, OP_DV, OP_DOTX, OP_DOTY,
      OP_VEL, OP_WALL, OP_GRAV, OP_LOAD_OUT
   } dp_op_type;

   typedef enum logic [1:0] {SEL_PX, SEL_PY, SEL_DX, SEL_DY} div_sel_type;

   typedef enum logic [1:0] {WR_REQ, WR_A, WR_B} wr_sel_type;

   typedef struct packed {
      dp_op_type       op;
      div_sel_type     sel;
      logic [IDX_W-1:0] rd_addr;
      logic            wr_en;
      wr_sel_type      wr_sel;
      logic [IDX_W-1:0] wr_addr;
      logic [IDX_W-1:0] out_index;
      logic            out_last;
   } dp_cmd_type;

   typedef struct packed {
      logic contact;
      logic zero_dist;
      logic busy;
   } dp_status_type;

   function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] hi;
      logic signed [WIDE_W-1:0] lo;
      hi = 46'sd2047;
      lo = -46'sd2048;
      if (v > hi) begin
         return hi[POS_W-1:0];
      end else if (v < lo) begin
         return lo[POS_W-1:0];
      end
      return v[POS_W-1:0];
   endfunction

   // divide by 256 toward zero, then saturate
   function automatic logic signed [POS_W-1:0] trunc_pos(input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] q;
      q = v >>> 8;
      if (v[WIDE_W-1] && (v[7:0] != 8'd0)) begin
         q = q + 46'sd1;
      end
      return sat_pos(q);
   endfunction

   function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] hi;
      logic signed [WIDE_W-1:0] lo;
      hi = 46'sd32767;
      lo = -46'sd32768;
      if (v > hi) begin
         return hi[VEL_W-1:0];
      end else if (v < lo) begin
         return lo[VEL_W-1:0];
      end
      return v[VEL_W-1:0];
   endfunction

endpackage

// ----- hw/rtl/disc_collision_gravity_step_unit.sv -----
// ----------------------------------------------------------------------------
// disc_collision_gravity_step_unit
// equal-disc collision, wall and gravity step over a small disc table
// ----------------------------------------------------------------------------
// load: one transfer in, no result
// frame: results follow once every disc is updated; contacts are set by the
//   44-step shared divider (four divides per contact) and the 18-step root
//   unit; one item in flight
// reset: all disc slots read as zero, registers return to their defaults
// ----------------------------------------------------------------------------
module disc_collision_gravity_step_unit #(
   parameter int MAX_DISCS = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  dcg_pkg::req_item_type              req_data,
   // result channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output dcg_pkg::rsp_item_type              rsp_data,
   // register write channel
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [dcg_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [dcg_pkg::CSR_DATA_W-1:0]     csr_data
);

   // slots above eight are never addressed by a 3-bit index
   localparam int DEPTH = (MAX_DISCS < 8) ? MAX_DISCS : 8;

   dcg_pkg::cfg_type       cfg_ff, cfg_in;
   dcg_pkg::dp_cmd_type    cmd;
   dcg_pkg::dp_status_type status;

   // register file: always ready; the host writes it only between frames, which the block does not enforce
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            dcg_pkg::CSR_RIGHT_WALL:    cfg_in.right_wall    = csr_data;
            dcg_pkg::CSR_BOTTOM_WALL:   cfg_in.bottom_wall   = csr_data;
            dcg_pkg::CSR_DISC_RADIUS:   cfg_in.disc_radius   = csr_data[7:0];
            dcg_pkg::CSR_GRAVITY_STEP:  cfg_in.gravity_step  = csr_data[7:0];
            dcg_pkg::CSR_ACTIVE_COUNT:  cfg_in.active_count  = csr_data[3:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.right_wall    <= 11'd1280;
         cfg_ff.bottom_wall   <= 11'd720;
         cfg_ff.disc_radius   <= 8'd50;
         cfg_ff.gravity_step  <= 8'd26;
         cfg_ff.active_count  <= 4'd5;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // sequencer: disc loop, pair loop, contact steps, result drain
   dcg_ctrl #(
      .DEPTH(DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_is_frame(req_data.req_type == dcg_pkg::REQ_FRAME),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .active_count(cfg_ff.active_count),
      .status      (status),
      .cmd         (cmd)
   );

   // datapath: disc store, working registers, root and divide units,
   // output register holding each result until its transfer
   dcg_dp #(
      .DEPTH(DEPTH)
   ) u_dp (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .cmd     (cmd),
      .req_data(req_data),
      .status  (status),
      .rsp_data(rsp_data)
   );

endmodule

// ----- hw/rtl/dcg_ram.sv -----
// ----------------------------------------------------------------------------
// dcg_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module dcg_ram #(
   parameter int WIDTH = 56,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/dcg_dp.sv -----
// ----------------------------------------------------------------------------
// dcg_dp
// disc state store, working registers, root and divide units
// ----------------------------------------------------------------------------
module dcg_dp #(
   parameter int DEPTH = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dcg_pkg::cfg_type      cfg,
   input  dcg_pkg::dp_cmd_type   cmd,
   input  dcg_pkg::req_item_type req_data,
   output dcg_pkg::dp_status_type status,
   output dcg_pkg::rsp_item_type rsp_data
);

   localparam int AW    = $clog2(DEPTH);
   localparam int REC_W = $bits(dcg_pkg::disc_rec_type);

   typedef struct packed {
      logic signed [dcg_pkg::POS_W-1:0]  ax;
      logic signed [dcg_pkg::POS_W-1:0]  ay;
      logic signed [dcg_pkg::VEL_W-1:0]  avx;
      logic signed [dcg_pkg::VEL_W-1:0]  avy;
      logic signed [dcg_pkg::POS_W-1:0]  bx;
      logic signed [dcg_pkg::POS_W-1:0]  by;
      logic signed [dcg_pkg::VEL_W-1:0]  bvx;
      logic signed [dcg_pkg::VEL_W-1:0]  bvy;
      logic signed [dcg_pkg::DIFF_W-1:0] dx;
      logic signed [dcg_pkg::DIFF_W-1:0] dy;
      logic        [dcg_pkg::D2_W-1:0]   d2;
      logic        [dcg_pkg::R2_W-1:0]   r2sq;
      logic signed [dcg_pkg::DOT_W-1:0]  mul;
      logic        [dcg_pkg::ROOT_W-1:0] dq;
      logic signed [dcg_pkg::GAP_W-1:0]  gap;
      logic signed [dcg_pkg::PROD_W-1:0] prod;
      logic signed [dcg_pkg::PROD_W-1:0] q0;
      logic signed [dcg_pkg::PROD_W-1:0] q1;
      logic signed [dcg_pkg::DV_W-1:0]   dvx;
      logic signed [dcg_pkg::DV_W-1:0]   dvy;
      logic signed [dcg_pkg::DOT_W-1:0]  dot;
   } work_type;

   typedef struct packed {
      logic                      busy;
      logic [dcg_pkg::SQ_W-1:0]  v;
      logic [dcg_pkg::SQ_W-1:0]  r;
      logic [dcg_pkg::SQ_W-1:0]  b;
   } sqrt_type;

   typedef struct packed {
      logic                        busy;
      logic                        neg;
      logic [dcg_pkg::DCNT_W-1:0]  cnt;
      logic [dcg_pkg::DVS_W-1:0]   rem;
      logic [dcg_pkg::DIVD_W-1:0]  quo;
      logic [dcg_pkg::DVS_W-1:0]   dvs;
   } div_type;

   work_type              wk_ff, wk_in;
   sqrt_type              sq_ff, sq_in;
   div_type               dv_ff, dv_in;
   dcg_pkg::rsp_item_type out_ff, out_in;
   logic [DEPTH-1:0]      valid_ff, valid_in;
   logic                  rd_ok_ff, rd_ok_in;

   logic                  ram_wr_en;
   logic [AW-1:0]         ram_wr_addr;
   logic [AW-1:0]         ram_rd_addr;
   logic [REC_W-1:0]      ram_wr_data;
   logic [REC_W-1:0]      ram_rd_data;
   dcg_pkg::disc_rec_type rec;
   dcg_pkg::disc_rec_type wr_rec;
   logic                  load_ok;

   // ---- store ----
   assign load_ok     = (int'(req_data.disc_index) < DEPTH);
   assign ram_rd_addr = cmd.rd_addr[AW-1:0];

   always_comb begin
      wr_rec      = '{x: wk_ff.ax, y: wk_ff.ay, vx: wk_ff.avx, vy: wk_ff.avy};
      ram_wr_addr = cmd.wr_addr[AW-1:0];
      ram_wr_en   = cmd.wr_en;
      case (cmd.wr_sel)
         dcg_pkg::WR_REQ: begin
            wr_rec = '{x: req_data.load_x, y: req_data.load_y,
                       vx: req_data.load_vx, vy: req_data.load_vy};
            ram_wr_addr = req_data.disc_index[AW-1:0];
            ram_wr_en   = cmd.wr_en && load_ok;
         end
         dcg_pkg::WR_B: begin
            wr_rec = '{x: wk_ff.bx, y: wk_ff.by, vx: wk_ff.bvx, vy: wk_ff.bvy};
         end
         default: begin
         end
      endcase
      ram_wr_data = wr_rec;
   end

   dcg_ram #(
      .WIDTH(REC_W),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   // never-written slots read as zero
   always_comb begin
      valid_in = valid_ff;
      if (ram_wr_en) begin
         valid_in[ram_wr_addr] = 1'b1;
      end
      rd_ok_in = valid_ff[ram_rd_addr];
      rec      = rd_ok_ff ? dcg_pkg::disc_rec_type'(ram_rd_data) : '0;
   end

   // ---- working logic ----
   always_comb begin
      logic signed [dcg_pkg::WIDE_W-1:0] ax_w, ay_w, avx_w, avy_w;
      logic signed [dcg_pkg::WIDE_W-1:0] bx_w, by_w, bvx_w, bvy_w;
      logic signed [dcg_pkg::WIDE_W-1:0] q0_w, q1_w, two_r_w, wid_w, hgt_w, grav_w;
      logic signed [dcg_pkg::DOT_W-1:0]  sum_w;
      logic signed [31:0]                pp_w;
      logic signed [dcg_pkg::PROD_W-1:0] pl_w, mag_w;
      logic [dcg_pkg::SQ_W-1:0]          s_trial;
      logic [dcg_pkg::DVS_W:0]           d_trial;
      logic [8:0]                        two_r;

      wk_in  = wk_ff;
      sq_in  = sq_ff;
      dv_in  = dv_ff;
      out_in = out_ff;

      two_r   = {cfg.disc_radius, 1'b0};
      ax_w    = wk_ff.ax;
      ay_w    = wk_ff.ay;
      avx_w   = wk_ff.avx;
      avy_w   = wk_ff.avy;
      bx_w    = wk_ff.bx;
      by_w    = wk_ff.by;
      bvx_w   = wk_ff.bvx;
      bvy_w   = wk_ff.bvy;
      q0_w    = wk_ff.q0;
      q1_w    = wk_ff.q1;
      two_r_w = $signed({37'd0, two_r});
      wid_w   = $signed({35'd0, cfg.right_wall});
      hgt_w   = $signed({35'd0, cfg.bottom_wall});
      grav_w  = $signed({38'd0, cfg.gravity_step});
      sum_w   = '0;
      pp_w    = '0;
      pl_w    = '0;
      mag_w   = '0;
      s_trial = '0;
      d_trial = '0;

      // root: two bits a step
      if (sq_ff.busy) begin
         if (sq_ff.b != '0) begin
            s_trial = sq_ff.r + sq_ff.b;
            if (sq_ff.v >= s_trial) begin
               sq_in.v = sq_ff.v - s_trial;
               sq_in.r = (sq_ff.r >> 1) + sq_ff.b;
            end else begin
               sq_in.r = sq_ff.r >> 1;
            end
            sq_in.b = sq_ff.b >> 2;
         end else begin
            sq_in.busy = 1'b0;
            wk_in.dq   = sq_ff.r[dcg_pkg::ROOT_W-1:0];
         end
      end

      // restoring divide: one quotient bit a step
      if (dv_ff.busy) begin
         d_trial = {dv_ff.rem, dv_ff.quo[dcg_pkg::DIVD_W-1]};
         if (d_trial >= {1'b0, dv_ff.dvs}) begin
            dv_in.rem = dcg_pkg::DVS_W'(d_trial - {1'b0, dv_ff.dvs});
            dv_in.quo = {dv_ff.quo[dcg_pkg::DIVD_W-2:0], 1'b1};
         end else begin
            dv_in.rem = d_trial[dcg_pkg::DVS_W-1:0];
            dv_in.quo = {dv_ff.quo[dcg_pkg::DIVD_W-2:0], 1'b0};
         end
         dv_in.cnt = dv_ff.cnt - 1'b1;
         if (dv_ff.cnt == dcg_pkg::DCNT_W'(1)) begin
            dv_in.busy = 1'b0;
         end
      end

      case (cmd.op)
         dcg_pkg::OP_LOAD_A: begin
            wk_in.ax   = rec.x;
            wk_in.ay   = rec.y;
            wk_in.avx  = rec.vx;
            wk_in.avy  = rec.vy;
            wk_in.r2sq = two_r * two_r;
         end
         dcg_pkg::OP_LOAD_B: begin
            wk_in.bx  = rec.x;
            wk_in.by  = rec.y;
            wk_in.bvx = rec.vx;
            wk_in.bvy = rec.vy;
         end
         dcg_pkg::OP_MOVE: begin
            wk_in.ax = dcg_pkg::trunc_pos((ax_w <<< 8) + avx_w);
            wk_in.ay = dcg_pkg::trunc_pos((ay_w <<< 8) + avy_w);
         end
         dcg_pkg::OP_DIFF: begin
            wk_in.dx = dcg_pkg::DIFF_W'(bx_w - ax_w);
            wk_in.dy = dcg_pkg::DIFF_W'(by_w - ay_w);
         end
         dcg_pkg::OP_SQX: begin
            wk_in.mul = $signed(wk_ff.dx) * $signed(wk_ff.dx);
         end
         dcg_pkg::OP_SQY: begin
            sum_w    = $signed(wk_ff.mul) + $signed(wk_ff.dy) * $signed(wk_ff.dy);
            wk_in.d2 = sum_w[dcg_pkg::D2_W-1:0];
         end
         dcg_pkg::OP_ZERO: begin
            wk_in.ax = dcg_pkg::sat_pos(ax_w + two_r_w);
         end
         dcg_pkg::OP_SQRT: begin
            sq_in.busy = 1'b1;
            sq_in.v    = {wk_ff.d2[dcg_pkg::ROOT_W-1:0], 16'h0000, 2'b00} >> 2;
            sq_in.r    = '0;
            sq_in.b    = dcg_pkg::SQ_W'(1) << (dcg_pkg::SQ_W - 2);
         end
         dcg_pkg::OP_GAP: begin
            wk_in.gap = $signed({2'b00, cfg.disc_radius, 9'd0}) - $signed({1'b0, wk_ff.dq});
         end
         dcg_pkg::OP_PROD: begin
            case (cmd.sel)
               dcg_pkg::SEL_PX: begin
                  pp_w       = $signed(wk_ff.dx) * $signed(wk_ff.gap);
                  pl_w       = pp_w;
                  wk_in.prod = pl_w <<< 7;
               end
               dcg_pkg::SEL_PY: begin
                  pp_w       = $signed(wk_ff.dy) * $signed(wk_ff.gap);
                  pl_w       = pp_w;
                  wk_in.prod = pl_w <<< 7;
               end
               dcg_pkg::SEL_DX: begin
                  wk_in.prod = $signed(wk_ff.dot) * $signed(wk_ff.dx);
               end
               default: begin
                  wk_in.prod = $signed(wk_ff.dot) * $signed(wk_ff.dy);
               end
            endcase
         end
         dcg_pkg::OP_DIV: begin
            mag_w      = wk_ff.prod[dcg_pkg::PROD_W-1] ? -wk_ff.prod : wk_ff.prod;
            dv_in.busy = 1'b1;
            dv_in.neg  = wk_ff.prod[dcg_pkg::PROD_W-1];
            dv_in.cnt  = dcg_pkg::DCNT_W'(dcg_pkg::DIVD_W);
            dv_in.rem  = '0;
            dv_in.quo  = mag_w[dcg_pkg::DIVD_W-1:0];
            if (cmd.sel == dcg_pkg::SEL_PX || cmd.sel == dcg_pkg::SEL_PY) begin
               dv_in.dvs = wk_ff.dq;
            end else begin
               dv_in.dvs = wk_ff.d2[dcg_pkg::DVS_W-1:0];
            end
         end
         dcg_pkg::OP_TAKE: begin
            pl_w = $signed({1'b0, dv_ff.quo});
            if (dv_ff.neg) begin
               pl_w = -pl_w;
            end
            if (cmd.sel == dcg_pkg::SEL_PX || cmd.sel == dcg_pkg::SEL_DX) begin
               wk_in.q0 = pl_w;
            end else begin
               wk_in.q1 = pl_w;
            end
         end
         dcg_pkg::OP_PUSH: begin
            wk_in.bx = dcg_pkg::trunc_pos((bx_w <<< 8) + q0_w);
            wk_in.by = dcg_pkg::trunc_pos((by_w <<< 8) + q1_w);
            wk_in.ax = dcg_pkg::trunc_pos((ax_w <<< 8) - q0_w);
            wk_in.ay = dcg_pkg::trunc_pos((ay_w <<< 8) - q1_w);
         end
         dcg_pkg::OP_DV: begin
            wk_in.dvx = dcg_pkg::DV_W'(bvx_w - avx_w);
            wk_in.dvy = dcg_pkg::DV_W'(bvy_w - avy_w);
         end
         dcg_pkg::OP_DOTX: begin
            wk_in.mul = $signed(wk_ff.dvx) * $signed(wk_ff.dx);
         end
         dcg_pkg::OP_DOTY: begin
            wk_in.dot = $signed(wk_ff.mul) + $signed(wk_ff.dvy) * $signed(wk_ff.dy);
         end
         dcg_pkg::OP_VEL: begin
            wk_in.avx = dcg_pkg::sat_vel(avx_w + q0_w);
            wk_in.avy = dcg_pkg::sat_vel(avy_w + q1_w);
            wk_in.bvx = dcg_pkg::sat_vel(bvx_w - q0_w);
            wk_in.bvy = dcg_pkg::sat_vel(bvy_w - q1_w);
         end
         dcg_pkg::OP_WALL: begin
            if (ax_w < 0) begin
               wk_in.ax  = '0;
               wk_in.avx = dcg_pkg::sat_vel(-avx_w);
            end else if (ax_w + two_r_w > wid_w) begin
               wk_in.ax  = dcg_pkg::sat_pos(wid_w - two_r_w);
               wk_in.avx = dcg_pkg::sat_vel(-avx_w);
            end
            if (ay_w < 0) begin
               wk_in.ay  = '0;
               wk_in.avy = dcg_pkg::sat_vel(-avy_w);
            end else if (ay_w + two_r_w > hgt_w) begin
               wk_in.ay  = dcg_pkg::sat_pos(hgt_w - two_r_w);
               wk_in.avy = dcg_pkg::sat_vel(-avy_w);
            end
         end
         dcg_pkg::OP_GRAV: begin
            wk_in.avy = dcg_pkg::sat_vel(avy_w + grav_w);
         end
         dcg_pkg::OP_LOAD_OUT: begin
            out_in.out_index = cmd.out_index;
            out_in.out_x     = rec.x;
            out_in.out_y     = rec.y;
            out_in.out_vx    = rec.vx;
            out_in.out_vy    = rec.vy;
            out_in.last_disc = cmd.out_last;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      wk_ff  <= wk_in;
      out_ff <= out_in;
      if (reset) begin
         sq_ff    <= '0;
         dv_ff    <= '0;
         valid_ff <= '0;
         rd_ok_ff <= 1'b0;
      end else begin
         sq_ff    <= sq_in;
         dv_ff    <= dv_in;
         valid_ff <= valid_in;
         rd_ok_ff <= rd_ok_in;
      end
   end

   assign status.contact   = (wk_ff.d2 < dcg_pkg::D2_W'(wk_ff.r2sq));
   assign status.zero_dist = (wk_ff.d2 == '0);
   assign status.busy      = sq_ff.busy | dv_ff.busy;
   assign rsp_data         = out_ff;

endmodule

// ----- hw/rtl/dcg_ctrl.sv -----
// ----------------------------------------------------------------------------
// dcg_ctrl
// frame sequencer: walks discs and pairs, issues datapath commands
// ----------------------------------------------------------------------------
module dcg_ctrl #(
   parameter int DEPTH = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_is_frame,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic [3:0]                  active_count,
   input  dcg_pkg::dp_status_type      status,
   output dcg_pkg::dp_cmd_type         cmd
);

   typedef enum logic [4:0] {
      S_IDLE, S_RD_A, S_LAT_A, S_MOVE, S_RD_B, S_LAT_B, S_DIFF, S_SQX, S_SQY,
      S_CHECK, S_ZERO, S_SQRT, S_SQ_WAIT, S_GAP, S_PROD, S_DIV, S_DIV_WAIT,
      S_TAKE, S_PUSH, S_DV, S_DOTX, S_DOTY, S_VEL, S_WR_B, S_WALL, S_GRAV,
      S_WR_A, S_OUT_RD, S_OUT_LAT, S_OUT_WAIT
   } state_type;

   state_type                   state_ff, state_in;
   logic [dcg_pkg::CNT_W-1:0]   i_ff, i_in, j_ff, j_in, n_ff, n_in, k_ff, k_in;
   dcg_pkg::div_sel_type        sel_ff, sel_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [dcg_pkg::CNT_W-1:0]   n_req;
   logic [dcg_pkg::CNT_W-1:0]   i_next, j_next, k_next;

   assign n_req  = (active_count > dcg_pkg::CNT_W'(DEPTH)) ? dcg_pkg::CNT_W'(DEPTH)
                                                           : active_count;
   assign i_next = i_ff + 1'b1;
   assign j_next = j_ff + 1'b1;
   assign k_next = k_ff + 1'b1;

   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      n_in         = n_ff;
      k_in         = k_ff;
      sel_in       = sel_ff;
      rsp_valid_in = rsp_valid_ff;

      cmd           = '0;
      cmd.op        = dcg_pkg::OP_NONE;
      cmd.sel       = sel_ff;
      cmd.wr_sel    = dcg_pkg::WR_A;
      cmd.wr_addr   = i_ff[dcg_pkg::IDX_W-1:0];
      cmd.rd_addr   = i_ff[dcg_pkg::IDX_W-1:0];
      cmd.out_index = k_ff[dcg_pkg::IDX_W-1:0];
      cmd.out_last  = (k_next == n_ff);

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_is_frame) begin
                  n_in = n_req;
                  i_in = '0;
                  if (n_req != '0) begin
                     state_in = S_RD_A;
                  end
               end else begin
                  cmd.wr_en  = 1'b1;
                  cmd.wr_sel = dcg_pkg::WR_REQ;
               end
            end
         end
         S_RD_A: state_in = S_LAT_A;
         S_LAT_A: begin
            cmd.op   = dcg_pkg::OP_LOAD_A;
            state_in = S_MOVE;
         end
         S_MOVE: begin
            cmd.op   = dcg_pkg::OP_MOVE;
            j_in     = i_next;
            state_in = (i_next < n_ff) ? S_RD_B : S_WALL;
         end
         S_RD_B: begin
            cmd.rd_addr = j_ff[dcg_pkg::IDX_W-1:0];
            state_in    = S_LAT_B;
         end
         S_LAT_B: begin
            cmd.op   = dcg_pkg::OP_LOAD_B;
            state_in = S_DIFF;
         end
         S_DIFF: begin
            cmd.op   = dcg_pkg::OP_DIFF;
            state_in = S_SQX;
         end
         S_SQX: begin
            cmd.op   = dcg_pkg::OP_SQX;
            state_in = S_SQY;
         end
         S_SQY: begin
            cmd.op   = dcg_pkg::OP_SQY;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (!status.contact) begin
               j_in     = j_next;
               state_in = (j_next < n_ff) ? S_RD_B : S_WALL;
            end else if (status.zero_dist) begin
               state_in = S_ZERO;
            end else begin
               state_in = S_SQRT;
            end
         end
         // coincident corners: shove disc i right and end its update
         S_ZERO: begin
            cmd.op   = dcg_pkg::OP_ZERO;
            state_in = S_WR_A;
         end
         S_SQRT: begin
            cmd.op   = dcg_pkg::OP_SQRT;
            state_in = S_SQ_WAIT;
         end
         S_SQ_WAIT: begin
            if (!status.busy) begin
               sel_in   = dcg_pkg::SEL_PX;
               state_in = S_GAP;
            end
         end
         S_GAP: begin
            cmd.op   = dcg_pkg::OP_GAP;
            state_in = S_PROD;
         end
         S_PROD: begin
            cmd.op   = dcg_pkg::OP_PROD;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.op   = dcg_pkg::OP_DIV;
            state_in = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (!status.busy) begin
               state_in = S_TAKE;
            end
         end
         S_TAKE: begin
            cmd.op = dcg_pkg::OP_TAKE;
            case (sel_ff)
               dcg_pkg::SEL_PX: begin
                  sel_in   = dcg_pkg::SEL_PY;
                  state_in = S_PROD;
               end
               dcg_pkg::SEL_PY: state_in = S_PUSH;
               dcg_pkg::SEL_DX: begin
                  sel_in   = dcg_pkg::SEL_DY;
                  state_in = S_PROD;
               end
               default: state_in = S_VEL;
            endcase
         end
         S_PUSH: begin
            cmd.op   = dcg_pkg::OP_PUSH;
            state_in = S_DV;
         end
         S_DV: begin
            cmd.op   = dcg_pkg::OP_DV;
            state_in = S_DOTX;
         end
         S_DOTX: begin
            cmd.op   = dcg_pkg::OP_DOTX;
            state_in = S_DOTY;
         end
         S_DOTY: begin
            cmd.op   = dcg_pkg::OP_DOTY;
            sel_in   = dcg_pkg::SEL_DX;
            state_in = S_PROD;
         end
         S_VEL: begin
            cmd.op   = dcg_pkg::OP_VEL;
            state_in = S_WR_B;
         end
         S_WR_B: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = dcg_pkg::WR_B;
            cmd.wr_addr = j_ff[dcg_pkg::IDX_W-1:0];
            j_in        = j_next;
            state_in    = (j_next < n_ff) ? S_RD_B : S_WALL;
         end
         S_WALL: begin
            cmd.op   = dcg_pkg::OP_WALL;
            state_in = S_GRAV;
         end
         S_GRAV: begin
            cmd.op   = dcg_pkg::OP_GRAV;
            state_in = S_WR_A;
         end
         S_WR_A: begin
            cmd.wr_en = 1'b1;
            if (i_next < n_ff) begin
               i_in     = i_next;
               state_in = S_RD_A;
            end else begin
               k_in     = '0;
               state_in = S_OUT_RD;
            end
         end
         S_OUT_RD: begin
            cmd.rd_addr = k_ff[dcg_pkg::IDX_W-1:0];
            state_in    = S_OUT_LAT;
         end
         S_OUT_LAT: begin
            cmd.op       = dcg_pkg::OP_LOAD_OUT;
            rsp_valid_in = 1'b1;
            state_in     = S_OUT_WAIT;
         end
         S_OUT_WAIT: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               if (k_next < n_ff) begin
                  k_in     = k_next;
                  state_in = S_OUT_RD;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         i_ff         <= '0;
         j_ff         <= '0;
         n_ff         <= '0;
         k_ff         <= '0;
         sel_ff       <= dcg_pkg::SEL_PX;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         n_ff         <= n_in;
         k_ff         <= k_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- verif/disc_collision_gravity_step_unit_tb.sv -----
// ----------------------------------------------------------------------------
// disc_collision_gravity_step_unit_tb
// self-checking bench: a disc-table predictor computes the expected result
// transfers of every frame, and a scoreboard compares them field by field
// under random valid/stall gaps, long receiver hold-offs and register phases
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module disc_collision_gravity_step_unit_tb;

   // indexes past the last register, written to check they are ignored
   localparam logic [dcg_pkg::CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd5;
   localparam logic [dcg_pkg::CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   // predictor of the disc table plus queue of expected result transfers
   class disc_scoreboard;
      longint                 pos_x [8];
      longint                 pos_y [8];
      longint                 vel_x [8];
      longint                 vel_y [8];
      longint                 scr_w, scr_h, radius, grav, count;
      dcg_pkg::rsp_item_type  pending_q[$];
      int                     errors, loads, frames, results;

      function new();
         for (int k = 0; k < 8; k++) begin
            pos_x[k] = 0; pos_y[k] = 0; vel_x[k] = 0; vel_y[k] = 0;
         end
         scr_w = 1280; scr_h = 720; radius = 50; grav = 26; count = 5;
      endfunction

      function void set_register(logic [dcg_pkg::CSR_IDX_W-1:0] idx,
                                 logic [dcg_pkg::CSR_DATA_W-1:0] val);
         case (idx)
            dcg_pkg::CSR_RIGHT_WALL:   scr_w  = val;
            dcg_pkg::CSR_BOTTOM_WALL:  scr_h  = val;
            dcg_pkg::CSR_DISC_RADIUS:  radius = val[7:0];
            dcg_pkg::CSR_GRAVITY_STEP: grav   = val[7:0];
            dcg_pkg::CSR_ACTIVE_COUNT: count  = val[3:0];
            default: ;
         endcase
      endfunction

      function longint clip_pos(longint v);
         return v < -2048 ? -2048 : (v > 2047 ? 2047 : v);
      endfunction

      function longint clip_vel(longint v);
         return v < -32768 ? -32768 : (v > 32767 ? 32767 : v);
      endfunction

      function longint int_root(longint unsigned v);
         longint unsigned r, b;
         r = 0;
         b = 64'h4000000000000000;
         while (b > v) b = b >> 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v = v - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return longint'(r);
      endfunction

      // true when the zero-distance shift ended disc i's update
      function bit resolve_contact(int i, int j);
         longint two_r, dx, dy, d2, dq, gap, px, py, dot, delx, dely;
         two_r = 2 * radius;
         dx = pos_x[j] - pos_x[i];
         dy = pos_y[j] - pos_y[i];
         d2 = dx * dx + dy * dy;
         if (d2 >= two_r * two_r) return 0;
         if (d2 == 0) begin
            pos_x[i] = clip_pos(pos_x[i] + two_r);
            return 1;
         end
         dq  = int_root(d2 * 65536);
         gap = 512 * radius - dq;
         px  = dx * gap * 128 / dq;
         py  = dy * gap * 128 / dq;
         pos_x[j] = clip_pos((pos_x[j] * 256 + px) / 256);
         pos_y[j] = clip_pos((pos_y[j] * 256 + py) / 256);
         pos_x[i] = clip_pos((pos_x[i] * 256 - px) / 256);
         pos_y[i] = clip_pos((pos_y[i] * 256 - py) / 256);
         dot  = (vel_x[j] - vel_x[i]) * dx + (vel_y[j] - vel_y[i]) * dy;
         delx = dot * dx / d2;
         dely = dot * dy / d2;
         vel_x[i] = clip_vel(vel_x[i] + delx);
         vel_y[i] = clip_vel(vel_y[i] + dely);
         vel_x[j] = clip_vel(vel_x[j] - delx);
         vel_y[j] = clip_vel(vel_y[j] - dely);
         return 0;
      endfunction

      function void advance_disc(int i, int n);
         longint two_r;
         two_r = 2 * radius;
         pos_x[i] = clip_pos((pos_x[i] * 256 + vel_x[i]) / 256);
         pos_y[i] = clip_pos((pos_y[i] * 256 + vel_y[i]) / 256);
         for (int j = i + 1; j < n; j++)
            if (resolve_contact(i, j)) return;
         if (pos_x[i] < 0) begin
            pos_x[i] = 0;
            vel_x[i] = clip_vel(-vel_x[i]);
         end else if (pos_x[i] + two_r > scr_w) begin
            pos_x[i] = clip_pos(scr_w - two_r);
            vel_x[i] = clip_vel(-vel_x[i]);
         end
         if (pos_y[i] < 0) begin
            pos_y[i] = 0;
            vel_y[i] = clip_vel(-vel_y[i]);
         end else if (pos_y[i] + two_r > scr_h) begin
            pos_y[i] = clip_pos(scr_h - two_r);
            vel_y[i] = clip_vel(-vel_y[i]);
         end
         vel_y[i] = clip_vel(vel_y[i] + grav);
      endfunction

      function void note_request(dcg_pkg::req_item_type req);
         int n;
         dcg_pkg::rsp_item_type e;
         if (req.req_type == dcg_pkg::REQ_LOAD) begin
            loads++;
            pos_x[req.disc_index] = req.load_x;
            pos_y[req.disc_index] = req.load_y;
            vel_x[req.disc_index] = req.load_vx;
            vel_y[req.disc_index] = req.load_vy;
            return;
         end
         frames++;
         n = (count > 8) ? 8 : int'(count);
         for (int i = 0; i < n; i++) advance_disc(i, n);
         for (int k = 0; k < n; k++) begin
            e.out_index = k[dcg_pkg::IDX_W-1:0];
            e.out_x     = pos_x[k][dcg_pkg::POS_W-1:0];
            e.out_y     = pos_y[k][dcg_pkg::POS_W-1:0];
            e.out_vx    = vel_x[k][dcg_pkg::VEL_W-1:0];
            e.out_vy    = vel_y[k][dcg_pkg::VEL_W-1:0];
            e.last_disc = (k == n - 1);
            pending_q.insert(pending_q.size(), e);
         end
      endfunction

      function void check_result(dcg_pkg::rsp_item_type got);
         dcg_pkg::rsp_item_type e;
         results++;
         if (pending_q.size() == 0) begin
            $error("unexpected result transfer, index %0d", got.out_index);
            errors++;
            return;
         end
         e = pending_q.pop_front();
         if (got.out_index !== e.out_index) begin
            $error("out_index exp %0d got %0d", e.out_index, got.out_index); errors++;
         end
         if (got.out_x !== e.out_x) begin
            $error("out_x exp %0d got %0d", e.out_x, got.out_x); errors++;
         end
         if (got.out_y !== e.out_y) begin
            $error("out_y exp %0d got %0d", e.out_y, got.out_y); errors++;
         end
         if (got.out_vx !== e.out_vx) begin
            $error("out_vx exp %0d got %0d", e.out_vx, got.out_vx); errors++;
         end
         if (got.out_vy !== e.out_vy) begin
            $error("out_vy exp %0d got %0d", e.out_vy, got.out_vy); errors++;
         end
         if (got.last_disc !== e.last_disc) begin
            $error("last_disc exp %0d got %0d", e.last_disc, got.last_disc); errors++;
         end
      endfunction
   endclass

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   dcg_pkg::req_item_type          req_data = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b1;
   dcg_pkg::rsp_item_type          rsp_data;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [dcg_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [dcg_pkg::CSR_DATA_W-1:0] csr_data = '0;

   disc_scoreboard sb = new();
   bit             long_hold_req = 0;
   bit             no_gaps = 0;

   always #1 clock = ~clock;

   disc_collision_gravity_step_unit u_top (
      .clock, .reset,
      .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   // sample both channels at the edge; results first so a frame accepted at
   // the same edge as the previous frame's last transfer queues behind it
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_data);
         if (req_valid && !req_stall) sb.note_request(req_data);
      end
   end

   // receiver: alternating stall and free stretches, with an on-demand
   // long hold-off so that a frame backs up and the input stalls
   initial begin : receiver
      int stall_left, free_left;
      stall_left = 0;
      free_left  = 0;
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            long_hold_req = 0;
            stall_left = 3000;
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else if (free_left > 0) begin
            rsp_stall <= 1'b0;
            free_left--;
         end else begin
            free_left  = $urandom_range(0, 20);
            stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3)
                                                    : $urandom_range(10, 80);
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic int pick_gap();
      if (no_gaps) return 0;
      return ($urandom_range(0, 9) < 7) ? $urandom_range(0, 2) : $urandom_range(8, 60);
   endfunction

   // one request transfer, then a random gap; valid stays high across
   // back-to-back transfers
   task automatic send_item(dcg_pkg::req_item_type item);
      int gap;
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // wait out every expected transfer plus the tail of a frame with no results
   task automatic drain();
      if (req_valid) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_reg(logic [dcg_pkg::CSR_IDX_W-1:0] idx,
                            logic [dcg_pkg::CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_register(idx, val);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_setting(int w, int h, int r, int g, int n);
      write_reg(dcg_pkg::CSR_RIGHT_WALL, w[10:0]);
      write_reg(dcg_pkg::CSR_BOTTOM_WALL, h[10:0]);
      write_reg(dcg_pkg::CSR_DISC_RADIUS, r[10:0]);
      write_reg(dcg_pkg::CSR_GRAVITY_STEP, g[10:0]);
      write_reg(dcg_pkg::CSR_ACTIVE_COUNT, n[10:0]);
   endtask

   function automatic dcg_pkg::req_item_type make_load(int idx, int x, int y, int vx, int vy);
      dcg_pkg::req_item_type it;
      it.req_type   = dcg_pkg::REQ_LOAD;
      it.disc_index = idx[dcg_pkg::IDX_W-1:0];
      it.load_x     = x[dcg_pkg::POS_W-1:0];
      it.load_y     = y[dcg_pkg::POS_W-1:0];
      it.load_vx    = vx[dcg_pkg::VEL_W-1:0];
      it.load_vy    = vy[dcg_pkg::VEL_W-1:0];
      return it;
   endfunction

   function automatic dcg_pkg::req_item_type make_frame();
      dcg_pkg::req_item_type it;
      it = $bits(dcg_pkg::req_item_type)'({$urandom, $urandom});
      it.req_type = dcg_pkg::REQ_FRAME;
      return it;
   endfunction

   function automatic dcg_pkg::req_item_type make_noise();
      dcg_pkg::req_item_type it;
      it = $bits(dcg_pkg::req_item_type)'({$urandom, $urandom});
      return it;
   endfunction

   // a cluster of discs close enough to touch, random small velocities
   task automatic send_cluster(int n);
      int bx, by, rr, span;
      rr   = int'(sb.radius);
      span = (3 * rr > 0) ? 3 * rr : 4;
      bx   = $urandom_range(0, (sb.scr_w > 0) ? int'(sb.scr_w) : 1);
      by   = $urandom_range(0, (sb.scr_h > 0) ? int'(sb.scr_h) : 1);
      for (int k = 0; k < n; k++) begin
         int x, y;
         x = bx + $urandom_range(0, span) - span / 2;
         y = by + $urandom_range(0, span) - span / 2;
         x = (x > 2047) ? 2047 : x;
         y = (y > 2047) ? 2047 : y;
         send_item(make_load(k, x, y, int'($urandom_range(0, 4096)) - 2048,
                             int'($urandom_range(0, 4096)) - 2048));
      end
   endtask

   initial begin : stimulus
      int n;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: a frame on the reset table, field extremes, zero distance,
      // overlap, wall hits on every side and velocity saturation
      send_item(make_frame());
      send_item(make_load(0, -2048, -2048, -32768, -32768));
      send_item(make_load(1, 2047, 2047, 32767, 32767));
      send_item(make_load(2, 300, 300, 0, 0));
      send_item(make_load(3, 300, 300, 256, -256));
      send_item(make_load(4, 340, 320, -512, 128));
      send_item(make_load(7, 0, 0, 0, 0));
      send_item(make_frame());
      send_item(make_frame());
      drain();
      apply_setting(2047, 2047, 255, 255, 8);
      send_item(make_load(5, 100, 100, 32767, -32768));
      send_item(make_load(6, 101, 99, -32768, 32767));
      send_item(make_frame());
      drain();
      apply_setting(1, 1, 1, 0, 1);
      send_item(make_frame());
      drain();
      apply_setting(0, 0, 0, 0, 0);
      send_item(make_frame());
      drain();
      apply_setting(640, 480, 20, 13, 15);
      write_reg(CSR_SPARE_LO, 11'h7ff);
      write_reg(CSR_SPARE_HI, 11'h000);
      send_item(make_frame());
      drain();

      // random phases: mostly clustered loads followed by frames
      for (int phase = 0; phase < 8; phase++) begin
         if (phase == 1) apply_setting(1280, 720, 50, 26, 5);
         else if (phase == 2) apply_setting(2047, 2047, 255, 255, 8);
         else if (phase == 3) apply_setting(1, 1, 1, 0, 1);
         else apply_setting($urandom_range(0, 2047), $urandom_range(0, 2047),
                            ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                        : $urandom_range(4, 40),
                            $urandom_range(0, 255), $urandom_range(0, 15));
         no_gaps = (phase == 4);
         n = (sb.count > 8) ? 8 : int'(sb.count);
         for (int round = 0; round < 5; round++) begin
            if (phase == 5 && round == 1) long_hold_req = 1;
            if (phase == 6 && round == 2) drain();
            if ($urandom_range(0, 4) == 0) send_item(make_noise());
            send_cluster($urandom_range(1, (n > 0) ? n : 1));
            repeat ($urandom_range(1, 3)) send_item(make_frame());
         end
         drain();
      end
      no_gaps = 0;

      drain();
      $display("covered %0d loads and %0d frames, %0d result transfers checked",
               sb.loads, sb.frames, sb.results);
      if (sb.errors == 0 && sb.pending_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin : watchdog
      #20000000;
      $display("FAILURE");
      $finish;
   end

endmodule
